// File: src/itf_pkg.sv
package itf_pkg;

   localparam int MAG_BITS   = 64;
   localparam int DIGITS     = 20;
   localparam int HEX_DIGITS = 16;
   localparam int MAX_TEXT   = 64;
   localparam int RESULT_CAP = 64;
   localparam int QDEPTH     = 2;
   localparam int QPTR_W     = 1;

   localparam logic [1:0] KIND_DEC   = 2'd0;
   localparam logic [1:0] KIND_LOWER = 2'd1;
   localparam logic [1:0] KIND_UPPER = 2'd2;

   localparam logic [1:0] SIGN_NONE  = 2'd0;
   localparam logic [1:0] SIGN_SPACE = 2'd1;
   localparam logic [1:0] SIGN_PLUS  = 2'd2;

   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2b;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_LOW_X = 8'h78;
   localparam logic [7:0] CH_UP_X  = 8'h58;
   localparam logic [7:0] CH_LOW_A = 8'h61;
   localparam logic [7:0] CH_UP_A  = 8'h41;

   // Classified request, as it waits between the front and the back
   typedef struct packed {
      logic [MAG_BITS-1:0] mag;
      logic                hex;
      logic                upper;
      logic                sign_on;
      logic [7:0]          sign_char;
      logic                prefix_on;
      logic                zero_pad;
      logic [6:0]          width_cap;
      logic                limit_on;
      logic [5:0]          limit;
   } item_type;

   function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
      logic [7:0] base;
      base = upper ? CH_UP_A : CH_LOW_A;
      if (d < 4'd10)
         return CH_ZERO + {4'd0, d};
      else
         return base + {4'd0, d} - 8'd10;
   endfunction

endpackage

// File: src/itf_front.sv
module itf_front (
   input  logic [1:0]            req_kind,
   input  logic [63:0]           req_value,
   input  logic                  req_is_signed,
   input  logic                  req_alt_prefix,
   input  logic [1:0]            req_sign_mode,
   input  logic                  req_zero_pad,
   input  logic [6:0]            req_field_width,
   input  logic [6:0]            req_max_length,
   output itf_pkg::item_type     item
);

   logic negative;
   logic hex;

   always_comb begin
      hex      = (req_kind == itf_pkg::KIND_LOWER) || (req_kind == itf_pkg::KIND_UPPER);
      negative = req_is_signed && req_value[itf_pkg::MAG_BITS-1];

      item.mag       = negative ? (64'd0 - req_value) : req_value;
      item.hex       = hex;
      item.upper     = (req_kind == itf_pkg::KIND_UPPER);
      item.prefix_on = hex && req_alt_prefix;
      item.zero_pad  = req_zero_pad;

      if (negative) begin
         item.sign_on   = 1'b1;
         item.sign_char = itf_pkg::CH_MINUS;
      end else if (req_sign_mode == itf_pkg::SIGN_SPACE) begin
         item.sign_on   = 1'b1;
         item.sign_char = itf_pkg::CH_SPACE;
      end else if (req_sign_mode == itf_pkg::SIGN_PLUS) begin
         item.sign_on   = 1'b1;
         item.sign_char = itf_pkg::CH_PLUS;
      end else begin
         item.sign_on   = 1'b0;
         item.sign_char = itf_pkg::CH_SPACE;
      end

      // clamp width to the result cap; lengths at or above the limit mean no cut
      if (req_field_width > 7'(itf_pkg::RESULT_CAP))
         item.width_cap = 7'(itf_pkg::RESULT_CAP);
      else
         item.width_cap = req_field_width;
      item.limit_on = (req_max_length < 7'(itf_pkg::MAX_TEXT));
      item.limit    = req_max_length[5:0];
   end

endmodule

// File: src/itf_queue.sv
module itf_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   output logic                  push_stall,
   input  itf_pkg::item_type     push_item,
   output logic                  pop_valid,
   input  logic                  pop,
   output itf_pkg::item_type     pop_item
);

   itf_pkg::item_type         ent_ff [itf_pkg::QDEPTH];
   logic [itf_pkg::QPTR_W-1:0] wr_ff, wr_in;
   logic [itf_pkg::QPTR_W-1:0] rd_ff, rd_in;
   logic [itf_pkg::QPTR_W:0]   cnt_ff, cnt_in;
   logic                       do_push, do_pop;

   always_comb begin
      push_stall = (cnt_ff == (itf_pkg::QPTR_W + 1)'(itf_pkg::QDEPTH));
      pop_valid  = (cnt_ff != '0);
      pop_item   = ent_ff[rd_ff];
      do_push    = push_valid && !push_stall;
      do_pop     = pop && pop_valid;
      wr_in      = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in      = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in     = cnt_ff + {{itf_pkg::QPTR_W{1'b0}}, do_push}
                          - {{itf_pkg::QPTR_W{1'b0}}, do_pop};
   end

   always_ff @(posedge clock) begin
      if (do_push)
         ent_ff[wr_ff] <= push_item;
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// File: src/itf_back.sv
module itf_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   output logic                  q_pop,
   input  itf_pkg::item_type     q_item,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_text_char,
   output logic                  rsp_last
);

   typedef enum logic [2:0] {
      IDLE,
      CONVERT,
      MEASURE,
      SIZE,
      EMIT
   } state_type;

   state_type                   state_ff, state_in;
   itf_pkg::item_type           cur_ff, cur_in;
   logic [itf_pkg::MAG_BITS-1:0] bin_ff, bin_in;
   logic [3:0]                  dig_ff [itf_pkg::DIGITS];
   logic [3:0]                  dig_in [itf_pkg::DIGITS];
   logic [5:0]                  bit_ff, bit_in;
   logic [4:0]                  ndig_ff, ndig_in;
   logic [4:0]                  len_ff, len_in;
   logic [6:0]                  pad_ff, pad_in;
   logic [6:0]                  total_ff, total_in;
   logic [6:0]                  k_ff, k_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [7:0]                  rsp_char_ff, rsp_char_in;
   logic                        rsp_last_ff, rsp_last_in;

   logic [3:0] adj [itf_pkg::DIGITS];
   logic       out_free;
   logic [4:0] nd;
   logic [4:0] actual;
   logic [6:0] pad;
   logic [6:0] diff;
   logic [4:0] j, j2, npre, p;
   logic [7:0] ch;
   logic       is_last;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_text_char = rsp_char_ff;
   assign rsp_last      = rsp_last_ff;

   always_comb begin
      // add-3 adjust of every BCD digit before the shift
      for (int i = 0; i < itf_pkg::DIGITS; i++)
         adj[i] = (dig_ff[i] >= 4'd5) ? dig_ff[i] + 4'd3 : dig_ff[i];

      nd = 5'd1;
      for (int i = 0; i < itf_pkg::DIGITS; i++)
         if (dig_ff[i] != 4'd0)
            nd = 5'(i + 1);

      actual = (cur_ff.limit_on && ({1'b0, len_ff} > cur_ff.limit))
               ? cur_ff.limit[4:0] : len_ff;
      pad    = (cur_ff.width_cap > {2'd0, actual}) ? cur_ff.width_cap - {2'd0, actual} : 7'd0;

      // character at position k of the output
      npre = cur_ff.prefix_on ? 5'd2 : 5'd0;
      diff = k_ff - pad_ff;
      j    = diff[4:0];
      j2   = j - {4'd0, cur_ff.sign_on};
      p    = ndig_ff - 5'd1 - j2 + npre;
      if (k_ff < pad_ff)
         ch = cur_ff.zero_pad ? itf_pkg::CH_ZERO : itf_pkg::CH_SPACE;
      else if (cur_ff.sign_on && (j == 5'd0))
         ch = cur_ff.sign_char;
      else if (j2 < npre)
         ch = (j2 == 5'd0) ? itf_pkg::CH_ZERO
                           : (cur_ff.upper ? itf_pkg::CH_UP_X : itf_pkg::CH_LOW_X);
      else
         ch = itf_pkg::digit_char(dig_ff[p], cur_ff.upper);
      is_last = ((k_ff + 7'd1) == total_ff);

      out_free = !rsp_valid_ff || !rsp_stall;

      state_in     = state_ff;
      cur_in       = cur_ff;
      bin_in       = bin_ff;
      dig_in       = dig_ff;
      bit_in       = bit_ff;
      ndig_in      = ndig_ff;
      len_in       = len_ff;
      pad_in       = pad_ff;
      total_in     = total_ff;
      k_in         = k_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      q_pop        = 1'b0;

      case (state_ff)
         IDLE: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               cur_in = q_item;
               bin_in = q_item.mag;
               bit_in = '0;
               for (int i = 0; i < itf_pkg::DIGITS; i++)
                  dig_in[i] = 4'd0;
               if (q_item.hex) begin
                  for (int i = 0; i < itf_pkg::HEX_DIGITS; i++)
                     dig_in[i] = q_item.mag[4*i +: 4];
                  state_in = MEASURE;
               end else begin
                  state_in = CONVERT;
               end
            end
         end
         CONVERT: begin
            dig_in[0] = {adj[0][2:0], bin_ff[itf_pkg::MAG_BITS-1]};
            for (int i = 1; i < itf_pkg::DIGITS; i++)
               dig_in[i] = {adj[i][2:0], adj[i-1][3]};
            bin_in = {bin_ff[itf_pkg::MAG_BITS-2:0], 1'b0};
            bit_in = bit_ff + 6'd1;
            if (bit_ff == 6'(itf_pkg::MAG_BITS - 1))
               state_in = MEASURE;
         end
         MEASURE: begin
            ndig_in  = nd;
            len_in   = nd + {4'd0, cur_ff.sign_on} + (cur_ff.prefix_on ? 5'd2 : 5'd0);
            state_in = SIZE;
         end
         SIZE: begin
            pad_in   = pad;
            total_in = pad + {2'd0, actual};
            k_in     = '0;
            state_in = ((pad + {2'd0, actual}) == 7'd0) ? IDLE : EMIT;
         end
         EMIT: begin
            // advance only when the output register is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = ch;
               rsp_last_in  = is_last;
               k_in         = k_ff + 7'd1;
               if (is_last)
                  state_in = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      bin_ff      <= bin_in;
      dig_ff      <= dig_in;
      bit_ff      <= bit_in;
      ndig_ff     <= ndig_in;
      len_ff      <= len_in;
      pad_ff      <= pad_in;
      total_ff    <= total_in;
      k_ff        <= k_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: src/integer_to_text_formatter_top.sv
// Integer to text formatter. Each request converts a 64-bit integer to decimal or hex ASCII,
// with optional sign, 0x/0X prefix, a length cut and left padding, and returns the text one
// character per rsp transaction with rsp_last on the final one (an empty result gives none).
// A two-entry queue sits behind the input, so up to two requests are taken while one is being
// worked on. The back end handles one request at a time: it loads the request from the queue,
// then converts decimal with a shift-and-adjust BCD loop over the 64 value bits (hex skips it),
// then sizes the text in MEASURE and SIZE, then emits the characters while rsp_stall is low.
module integer_to_text_formatter_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [63:0] req_value,
   input  logic        req_is_signed,
   input  logic        req_alt_prefix,
   input  logic [1:0]  req_sign_mode,
   input  logic        req_zero_pad,
   input  logic [6:0]  req_field_width,
   input  logic [6:0]  req_max_length,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_text_char,
   output logic        rsp_last
);

   itf_pkg::item_type front_item;
   itf_pkg::item_type q_item;
   logic              q_valid;
   logic              q_pop;

   itf_front u_front (
      .req_kind        (req_kind),
      .req_value       (req_value),
      .req_is_signed   (req_is_signed),
      .req_alt_prefix  (req_alt_prefix),
      .req_sign_mode   (req_sign_mode),
      .req_zero_pad    (req_zero_pad),
      .req_field_width (req_field_width),
      .req_max_length  (req_max_length),
      .item            (front_item)
   );

   itf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_stall (req_stall),
      .push_item  (front_item),
      .pop_valid  (q_valid),
      .pop        (q_pop),
      .pop_item   (q_item)
   );

   itf_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_pop         (q_pop),
      .q_item        (q_item),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_text_char (rsp_text_char),
      .rsp_last      (rsp_last)
   );

endmodule

// File: sim/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] KIND_SPARE = 2'd3;   // unassigned kind, converts as decimal
   localparam logic [1:0] SIGN_SPARE = 2'd3;   // unassigned sign mode, adds no sign
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int DRAIN_CYCLES   = 300;
   localparam int RANDOM_ITEMS   = 340;

   typedef struct {
      logic [1:0]  kind;
      logic [63:0] value;
      logic        sgn;
      logic        pfx;
      logic [1:0]  smode;
      logic        zpad;
      logic [6:0]  width;
      logic [6:0]  limit;
      bit          typed;
      string       text;
   } fmt_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_kind;
   logic [63:0] req_value;
   logic        req_is_signed;
   logic        req_alt_prefix;
   logic [1:0]  req_sign_mode;
   logic        req_zero_pad;
   logic [6:0]  req_field_width;
   logic [6:0]  req_max_length;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_text_char;
   logic        rsp_last;

   logic [7:0]  pending_char [$];
   logic        pending_last [$];
   logic [7:0]  want_char;
   logic        want_last;
   int          req_taken = 0;
   int          quiet_cycles = 0;
   int          error_count = 0;
   bit          calm = 1'b0;
   bit          cur_typed;
   string       cur_text;
   fmt_row_type dir_rows [$];

   integer_to_text_formatter_top u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_value       (req_value),
      .req_is_signed   (req_is_signed),
      .req_alt_prefix  (req_alt_prefix),
      .req_sign_mode   (req_sign_mode),
      .req_zero_pad    (req_zero_pad),
      .req_field_width (req_field_width),
      .req_max_length  (req_max_length),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_text_char   (rsp_text_char),
      .rsp_last        (rsp_last)
   );

   always #2 clock = ~clock;

   // Build the formatted text for one request and queue its characters.
   function automatic void predict_text(input logic [1:0] kind, input logic [63:0] value,
                                        input logic sgn, input logic pfx,
                                        input logic [1:0] smode, input logic zpad,
                                        input logic [6:0] width, input logic [6:0] limit);
      logic [7:0]  text [$];
      logic [63:0] mag;
      logic [3:0]  nib;
      logic        hex;
      logic        upper;
      logic        neg;
      int          cut;
      int          span;
      int          pad;
      hex   = (kind == itf_pkg::KIND_LOWER) || (kind == itf_pkg::KIND_UPPER);
      upper = (kind == itf_pkg::KIND_UPPER);
      neg   = sgn && value[63];
      mag   = neg ? (64'd0 - value) : value;
      if (mag == 64'd0)
         text.push_front(itf_pkg::CH_ZERO);
      while (mag != 64'd0) begin
         if (hex) begin
            nib = mag[3:0];
            if (nib < 4'd10)
               text.push_front(itf_pkg::CH_ZERO + 8'(nib));
            else
               text.push_front((upper ? itf_pkg::CH_UP_A : itf_pkg::CH_LOW_A)
                               + 8'(nib) - 8'd10);
            mag = mag >> 4;
         end else begin
            text.push_front(itf_pkg::CH_ZERO + 8'(mag % 64'd10));
            mag = mag / 64'd10;
         end
      end
      if (hex && pfx) begin
         text.push_front(upper ? itf_pkg::CH_UP_X : itf_pkg::CH_LOW_X);
         text.push_front(itf_pkg::CH_ZERO);
      end
      if (neg)
         text.push_front(itf_pkg::CH_MINUS);
      else if (smode == itf_pkg::SIGN_SPACE)
         text.push_front(itf_pkg::CH_SPACE);
      else if (smode == itf_pkg::SIGN_PLUS)
         text.push_front(itf_pkg::CH_PLUS);
      cut = text.size();
      if (int'(limit) < itf_pkg::MAX_TEXT && int'(limit) < cut)
         cut = int'(limit);
      span = int'(width);
      if (span > itf_pkg::MAX_TEXT)
         span = itf_pkg::MAX_TEXT;
      if (span > itf_pkg::RESULT_CAP)
         span = itf_pkg::RESULT_CAP;
      pad = (span > cut) ? span - cut : 0;
      for (int k = 0; k < pad + cut; k++) begin
         pending_char.push_back((k < pad) ? (zpad ? itf_pkg::CH_ZERO : itf_pkg::CH_SPACE)
                                          : text[k - pad]);
         pending_last.push_back(k == pad + cut - 1);
      end
   endfunction

   function automatic void expect_literal(input string s);
      for (int i = 0; i < s.len(); i++) begin
         pending_char.push_back(s[i]);
         pending_last.push_back(i == s.len() - 1);
      end
   endfunction

   function automatic fmt_row_type row(input logic [1:0] kind, input logic [63:0] value,
                                       input logic sgn, input logic pfx,
                                       input logic [1:0] smode, input logic zpad,
                                       input logic [6:0] width, input logic [6:0] limit,
                                       input bit typed, input string text);
      fmt_row_type r;
      r.kind  = kind;
      r.value = value;
      r.sgn   = sgn;
      r.pfx   = pfx;
      r.smode = smode;
      r.zpad  = zpad;
      r.width = width;
      r.limit = limit;
      r.typed = typed;
      r.text  = text;
      return r;
   endfunction

   function automatic fmt_row_type random_row();
      fmt_row_type r;
      logic [63:0] v;
      case ($urandom_range(0, 7))
         0: v = 64'($urandom_range(0, 20));
         1: v = '1;
         2: v = {1'b1, 63'd0};
         3: v = 64'd0 - 64'($urandom_range(1, 1000));
         4: v = {$urandom, $urandom} >> $urandom_range(0, 63);
         default: v = {$urandom, $urandom};
      endcase
      r.kind  = ($urandom_range(0, 19) == 0) ? KIND_SPARE : 2'($urandom_range(0, 2));
      r.value = v;
      r.sgn   = 1'($urandom_range(0, 1));
      r.pfx   = 1'($urandom_range(0, 1));
      r.smode = ($urandom_range(0, 19) == 0) ? SIGN_SPARE : 2'($urandom_range(0, 2));
      r.zpad  = 1'($urandom_range(0, 1));
      r.width = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(25, 127))
                                            : 7'($urandom_range(0, 24));
      case ($urandom_range(0, 9))
         0, 1, 2: r.limit = 7'($urandom_range(0, 63));
         3:       r.limit = 7'($urandom_range(64, 127));
         4, 5:    r.limit = 7'd127;
         default: r.limit = 7'd64;
      endcase
      r.typed = 1'b0;
      r.text  = "";
      return r;
   endfunction

   // Present one transaction from a falling edge and hold it until accepted.
   task automatic send(input fmt_row_type r);
      int seen;
      while (!calm && $urandom_range(0, 99) < 7) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_kind        = r.kind;
      req_value       = r.value;
      req_is_signed   = r.sgn;
      req_alt_prefix  = r.pfx;
      req_sign_mode   = r.smode;
      req_zero_pad    = r.zpad;
      req_field_width = r.width;
      req_max_length  = r.limit;
      cur_typed       = r.typed;
      cur_text        = r.text;
      req_valid       = 1'b1;
      seen = req_taken;
      do @(negedge clock); while (req_taken == seen);
   endtask

   always @(negedge clock)
      rsp_stall <= !calm && ($urandom_range(0, 99) < 7);

   always @(posedge clock) begin
      if (!reset) begin
         quiet_cycles = quiet_cycles + 1;
         if (req_valid && !req_stall) begin
            quiet_cycles = 0;
            req_taken = req_taken + 1;
            if (cur_typed)
               expect_literal(cur_text);
            else
               predict_text(req_kind, req_value, req_is_signed, req_alt_prefix,
                            req_sign_mode, req_zero_pad, req_field_width, req_max_length);
         end
         if (rsp_valid && !rsp_stall) begin
            quiet_cycles = 0;
            if (pending_char.size() == 0) begin
               error_count = error_count + 1;
               $error("rsp transaction with nothing pending: text_char %h last %b",
                      rsp_text_char, rsp_last);
            end else begin
               want_char = pending_char.pop_front();
               want_last = pending_last.pop_front();
               if (rsp_text_char !== want_char) begin
                  error_count = error_count + 1;
                  $error("text_char: expected %h, actual %h", want_char, rsp_text_char);
               end
               if (rsp_last !== want_last) begin
                  error_count = error_count + 1;
                  $error("last: expected %b, actual %b", want_last, rsp_last);
               end
            end
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: done, errors");
            $finish;
         end
      end
   end

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_kind        = itf_pkg::KIND_DEC;
      req_value       = '0;
      req_is_signed   = 1'b0;
      req_alt_prefix  = 1'b0;
      req_sign_mode   = itf_pkg::SIGN_NONE;
      req_zero_pad    = 1'b0;
      req_field_width = '0;
      req_max_length  = 7'd64;
      cur_typed       = 1'b0;
      cur_text        = "";

      // kind, value, signed, prefix, sign, zero pad, width, max length, typed, text
      dir_rows.push_back(row(itf_pkg::KIND_DEC, 64'd0,
                             0, 0, itf_pkg::SIGN_NONE, 0, 0, 64, 1, "0"));
      dir_rows.push_back(row(itf_pkg::KIND_DEC, '1,
                             0, 0, itf_pkg::SIGN_NONE, 0, 0, 64, 1,
                             "18446744073709551615"));
      dir_rows.push_back(row(itf_pkg::KIND_DEC, '1,
                             1, 0, itf_pkg::SIGN_NONE, 0, 0, 64, 1, "-1"));
      dir_rows.push_back(row(itf_pkg::KIND_DEC, {1'b1, 63'd0},
                             1, 0, itf_pkg::SIGN_NONE, 0, 0, 64, 1,
                             "-9223372036854775808"));
      dir_rows.push_back(row(itf_pkg::KIND_DEC, {1'b1, 63'd0},
                             0, 0, itf_pkg::SIGN_PLUS, 0, 0, 127, 1,
                             "+9223372036854775808"));
      dir_rows.push_back(row(itf_pkg::KIND_LOWER, '1,
                             0, 1, itf_pkg::SIGN_NONE, 0, 0, 64, 1,
                             "0xffffffffffffffff"));
      dir_rows.push_back(row(itf_pkg::KIND_UPPER, '1,
                             0, 1, itf_pkg::SIGN_NONE, 0, 0, 64, 1,
                             "0XFFFFFFFFFFFFFFFF"));
      dir_rows.push_back(row(itf_pkg::KIND_LOWER, 64'd0,
                             1, 1, itf_pkg::SIGN_NONE, 0, 0, 64, 1, "0x0"));
      dir_rows.push_back(row(itf_pkg::KIND_UPPER, 64'hABCDEF,
                             0, 0, itf_pkg::SIGN_PLUS, 0, 0, 64, 1, "+ABCDEF"));
      dir_rows.push_back(row(itf_pkg::KIND_DEC, 64'd5,
                             1, 0, itf_pkg::SIGN_SPACE, 0, 0, 64, 1, " 5"));
      dir_rows.push_back(row(itf_pkg::KIND_DEC, 64'd0 - 64'd5,
                             1, 0, itf_pkg::SIGN_NONE, 1, 5, 64, 1, "000-5"));
      dir_rows.push_back(row(itf_pkg::KIND_DEC, 64'd42,
                             0, 0, itf_pkg::SIGN_NONE, 0, 6, 64, 1, "    42"));
      dir_rows.push_back(row(itf_pkg::KIND_DEC, 64'd42,
                             0, 1, itf_pkg::SIGN_NONE, 0, 0, 64, 1, "42"));
      dir_rows.push_back(row(KIND_SPARE, 64'd123,
                             0, 1, itf_pkg::SIGN_NONE, 0, 0, 64, 1, "123"));
      dir_rows.push_back(row(itf_pkg::KIND_DEC, 64'd7,
                             0, 0, SIGN_SPARE, 0, 0, 64, 1, "7"));
      dir_rows.push_back(row(itf_pkg::KIND_DEC, 64'd99,
                             0, 0, itf_pkg::SIGN_PLUS, 1, 0, 0, 1, ""));
      dir_rows.push_back(row(itf_pkg::KIND_DEC, 64'd123456,
                             0, 0, itf_pkg::SIGN_NONE, 0, 0, 3, 1, "123"));
      dir_rows.push_back(row(itf_pkg::KIND_DEC, 64'd123456,
                             0, 0, itf_pkg::SIGN_NONE, 0, 0, 127, 1, "123456"));
      dir_rows.push_back(row(itf_pkg::KIND_DEC, 64'd9,
                             0, 0, itf_pkg::SIGN_PLUS, 0, 0, 1, 1, "+"));
      dir_rows.push_back(row(itf_pkg::KIND_LOWER, {1'b1, 63'd0},
                             1, 1, itf_pkg::SIGN_NONE, 0, 0, 64, 1,
                             "-0x8000000000000000"));
      // widths up to and past the cap, with and without a cut
      dir_rows.push_back(row(itf_pkg::KIND_DEC, 64'd1,
                             0, 0, itf_pkg::SIGN_NONE, 1, 127, 64, 0, ""));
      dir_rows.push_back(row(itf_pkg::KIND_LOWER, 64'hFF,
                             1, 1, itf_pkg::SIGN_PLUS, 0, 64, 63, 0, ""));
      dir_rows.push_back(row(itf_pkg::KIND_DEC, '1,
                             1, 0, itf_pkg::SIGN_SPACE, 0, 127, 0, 0, ""));
      dir_rows.push_back(row(itf_pkg::KIND_UPPER, '1,
                             1, 1, itf_pkg::SIGN_PLUS, 1, 20, 5, 0, ""));
      dir_rows.push_back(row(itf_pkg::KIND_DEC, '1,
                             0, 0, itf_pkg::SIGN_PLUS, 0, 65, 63, 0, ""));

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir_rows[i])
         send(dir_rows[i]);
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         calm = (n >= 150 && n < 230);
         send(random_row());
      end
      calm = 1'b0;
      req_valid = 1'b0;

      while (pending_char.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (error_count == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

endmodule

// File: files.f
src/itf_pkg.sv
src/itf_front.sv
src/itf_queue.sv
src/itf_back.sv
src/integer_to_text_formatter_top.sv
sim/tb.sv
